FILE: rtl/xss_pkg.sv
package xss_pkg;

    localparam int MAX_PERM = 64;
    localparam int PERM_W   = $clog2(MAX_PERM);
    localparam int CNT_W    = $clog2(MAX_PERM + 1);

    localparam int OP_W    = 2;
    localparam int SEED_W  = 64;
    localparam int BOUND_W = 31;
    localparam int VALUE_W = 64;

    localparam logic [OP_W-1:0] OP_SEED    = 2'd0;
    localparam logic [OP_W-1:0] OP_RAW     = 2'd1;
    localparam logic [OP_W-1:0] OP_BOUNDED = 2'd2;
    localparam logic [OP_W-1:0] OP_PERM    = 2'd3;

    localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [SEED_W-1:0]  t_seed;
    typedef logic [BOUND_W-1:0] t_bound;
    typedef logic [VALUE_W-1:0] t_value;

endpackage

FILE: rtl/xss_in_if.sv
interface xss_in_if;
    logic             valid;
    logic             ready;
    xss_pkg::t_op     op;
    xss_pkg::t_seed   seed_value;
    xss_pkg::t_bound  bound;

    modport source(output valid, op, seed_value, bound, input ready);
    modport sink(input valid, op, seed_value, bound, output ready);
endinterface

FILE: rtl/xss_out_if.sv
interface xss_out_if;
    logic             valid;
    logic             ready;
    xss_pkg::t_value  value;
    logic             last;

    modport source(output valid, value, last, input ready);
    modport sink(input valid, value, last, output ready);
endinterface

FILE: rtl/xss_ram.sv
module xss_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/xoshiro256ss_rng_with_shuffle.sv
// xoshiro256** generator with splitmix64 seeding and a Fisher-Yates shuffle.
// i_in carries one request per transaction: op, seed_value, bound. o_out
// returns 64-bit values with a last flag on the final value of a request.
// All arithmetic runs through one registered 32x32 multiplier and a few
// 64-bit adders under a small sequencer; i_in is ready only while idle.
// Work per request, from the accepting edge back to ready:
//   raw word        two shift-add steps for the output scrambler
//   bounded integer a raw word plus two passes through the multiplier
//   seed            four words, two 64-bit products each
//   permutation     fill of n entries, n-1 swaps of one bounded draw
//                   each, then a registered store read per entry
// Results sit in an output register; the next request is accepted while
// a result still waits there. A stalled o_out holds the sequencer at its
// next result. Reset clears the generator state to zero (every draw is
// zero until seeded) and empties the output register.
module xoshiro256ss_rng_with_shuffle (
    input  logic  i_clk,
    input  logic  i_rst_n,
    xss_in_if.sink    i_in,
    xss_out_if.source o_out
);

    localparam int PW = xss_pkg::PERM_W;
    localparam int CW = xss_pkg::CNT_W;
    localparam int BW = xss_pkg::BOUND_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SX1  = 4'd1;
    localparam logic [3:0] ST_SX2  = 4'd2;
    localparam logic [3:0] ST_SX3  = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_NW1  = 4'd5;
    localparam logic [3:0] ST_NW2  = 4'd6;
    localparam logic [3:0] ST_RES  = 4'd7;
    localparam logic [3:0] ST_FILL = 4'd8;
    localparam logic [3:0] ST_SW0  = 4'd9;
    localparam logic [3:0] ST_SW1  = 4'd10;
    localparam logic [3:0] ST_SW2  = 4'd11;
    localparam logic [3:0] ST_SW3  = 4'd12;
    localparam logic [3:0] ST_ERD  = 4'd13;
    localparam logic [3:0] ST_ELD  = 4'd14;

    localparam logic [1:0] MD_MUL1 = 2'd0;
    localparam logic [1:0] MD_MUL2 = 2'd1;
    localparam logic [1:0] MD_BND  = 2'd2;

    logic [3:0]          r_st;
    logic [1:0]          r_mode;
    logic [1:0]          r_ph;
    xss_pkg::t_op        r_op;
    logic [63:0]         r_s [4];
    logic [1:0]          r_w;
    logic [63:0]         r_acc;
    logic [63:0]         r_z;
    logic [63:0]         r_p;
    logic [63:0]         r_t;
    logic [BW-1:0]       r_b;
    logic [CW-1:0]       r_n;
    logic [PW-1:0]       r_i;
    logic [PW-1:0]       r_j;
    logic [PW-1:0]       r_vi;
    logic                r_ov;
    logic [63:0]         r_oval;
    logic                r_olast;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_c;
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW-1:0] ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;
    logic          out_free;
    logic          out_load;
    logic          accept;
    logic [CW-1:0] n_sat;
    logic [63:0]   sh17;
    logic [63:0]   t2;
    logic [63:0]   t3;
    logic [63:0]   rot7;
    logic [63:0]   bnd_sum;
    logic          e_last;
    logic [PW-1:0] j_clamp;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign out_load = out_free && ((r_st == ST_RES) || (r_st == ST_ELD));
    assign n_sat    = (i_in.bound > BW'(xss_pkg::MAX_PERM)) ? CW'(xss_pkg::MAX_PERM)
                                                             : i_in.bound[CW-1:0];
    assign sh17     = {r_s[1][46:0], 17'd0};
    assign t2       = r_s[2] ^ r_s[0];
    assign t3       = r_s[3] ^ r_s[1];
    assign rot7     = {r_z[56:0], r_z[63:57]};
    assign bnd_sum  = r_p + {32'd0, r_t[63:32]};
    assign e_last   = ({1'b0, r_i} == (r_n - CW'(1)));
    assign j_clamp  = (r_z[BW-1:0] > BW'(r_i)) ? r_i : r_z[PW-1:0];

    assign mul_c = (r_mode == MD_MUL2) ? xss_pkg::SM_MUL2 : xss_pkg::SM_MUL1;

    always_comb begin
        mul_a = r_z[63:32];
        mul_b = mul_c[31:0];
        if (r_mode == MD_BND) begin
            mul_b = {1'b0, r_b};
            if (r_ph == 2'd0) begin
                mul_a = r_z[42:11];
            end else begin
                mul_a = {11'd0, r_z[63:43]};
            end
        end else begin
            case (r_ph)
                2'd0: begin
                    mul_a = r_z[31:0];
                    mul_b = mul_c[31:0];
                end
                2'd1: begin
                    mul_a = r_z[31:0];
                    mul_b = mul_c[63:32];
                end
                default: begin
                    mul_a = r_z[63:32];
                    mul_b = mul_c[31:0];
                end
            endcase
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = r_i;
        ram_raddr = r_i;
        unique case (r_st)
            ST_FILL: ram_we = 1'b1;
            ST_SW1:  ram_raddr = r_j;
            ST_SW2: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_SW3: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_vi;
            end
            default: ram_we = 1'b0;
        endcase
    end

    xss_ram #(
        .WIDTH (PW),
        .DEPTH (xss_pkg::MAX_PERM)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_p <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_ov  <= 1'b0;
            r_ph  <= 2'd0;
            r_w   <= 2'd0;
            for (int k = 0; k < 4; k++) begin
                r_s[k] <= '0;
            end
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (accept) begin
                        r_op <= i_in.op;
                        r_b  <= i_in.bound;
                        unique case (i_in.op) inside
                            xss_pkg::OP_SEED: begin
                                r_acc <= i_in.seed_value + xss_pkg::SM_GAMMA;
                                r_w   <= 2'd0;
                                r_st  <= ST_SX1;
                            end
                            xss_pkg::OP_RAW, xss_pkg::OP_BOUNDED: begin
                                r_st <= ST_NW1;
                            end
                            default: begin
                                r_n <= n_sat;
                                r_i <= '0;
                                if (n_sat != '0) begin
                                    r_st <= ST_FILL;
                                end
                            end
                        endcase
                    end
                end
                ST_SX1: begin
                    r_z    <= r_acc ^ (r_acc >> 30);
                    r_mode <= MD_MUL1;
                    r_ph   <= 2'd0;
                    r_st   <= ST_MUL;
                end
                ST_SX2: begin
                    r_z    <= r_z ^ (r_z >> 27);
                    r_mode <= MD_MUL2;
                    r_ph   <= 2'd0;
                    r_st   <= ST_MUL;
                end
                ST_SX3: begin
                    r_s[r_w] <= r_z ^ (r_z >> 31);
                    if (r_w == 2'd3) begin
                        r_st <= ST_IDLE;
                    end else begin
                        r_w   <= r_w + 2'd1;
                        r_acc <= r_acc + xss_pkg::SM_GAMMA;
                        r_st  <= ST_SX1;
                    end
                end
                ST_MUL: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_mode == MD_BND) begin
                        case (r_ph)
                            2'd0: ;
                            2'd1: r_t <= r_p;
                            default: begin
                                r_z  <= {21'd0, bnd_sum[63:21]};
                                r_st <= (r_op == xss_pkg::OP_BOUNDED) ? ST_RES : ST_SW0;
                            end
                        endcase
                    end else begin
                        case (r_ph)
                            2'd0: ;
                            2'd1: r_t <= r_p;
                            2'd2: r_t[63:32] <= r_t[63:32] + r_p[31:0];
                            default: begin
                                r_z  <= {r_t[63:32] + r_p[31:0], r_t[31:0]};
                                r_st <= (r_mode == MD_MUL1) ? ST_SX2 : ST_SX3;
                            end
                        endcase
                    end
                end
                ST_NW1: begin
                    r_z    <= r_s[1] + {r_s[1][61:0], 2'd0};
                    r_s[0] <= r_s[0] ^ t3;
                    r_s[1] <= r_s[1] ^ t2;
                    r_s[2] <= t2 ^ sh17;
                    r_s[3] <= {t3[18:0], t3[63:19]};
                    r_st   <= ST_NW2;
                end
                ST_NW2: begin
                    r_z <= rot7 + {rot7[60:0], 3'd0};
                    if (r_op == xss_pkg::OP_RAW) begin
                        r_st <= ST_RES;
                    end else begin
                        r_mode <= MD_BND;
                        r_ph   <= 2'd0;
                        r_st   <= ST_MUL;
                    end
                end
                ST_RES: begin
                    if (out_free) begin
                        r_oval  <= r_z;
                        r_olast <= 1'b1;
                        r_st    <= ST_IDLE;
                    end
                end
                ST_FILL: begin
                    if (e_last) begin
                        if (r_i == '0) begin
                            r_st <= ST_ERD;
                        end else begin
                            r_b  <= BW'(r_i) + BW'(1);
                            r_st <= ST_NW1;
                        end
                    end else begin
                        r_i <= r_i + PW'(1);
                    end
                end
                ST_SW0: begin
                    r_j  <= j_clamp;
                    r_st <= ST_SW1;
                end
                ST_SW1: begin
                    r_vi <= ram_rdata;
                    r_st <= ST_SW2;
                end
                ST_SW2: begin
                    r_st <= ST_SW3;
                end
                ST_SW3: begin
                    if (r_i == PW'(1)) begin
                        r_i  <= '0;
                        r_st <= ST_ERD;
                    end else begin
                        r_i  <= r_i - PW'(1);
                        r_b  <= BW'(r_i);
                        r_st <= ST_NW1;
                    end
                end
                ST_ERD: begin
                    r_st <= ST_ELD;
                end
                ST_ELD: begin
                    if (out_free) begin
                        r_oval  <= {{(64 - PW){1'b0}}, ram_rdata};
                        r_olast <= e_last;
                        if (e_last) begin
                            r_st <= ST_IDLE;
                        end else begin
                            r_i  <= r_i + PW'(1);
                            r_st <= ST_ERD;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_st == ST_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.value = r_oval;
    assign o_out.last  = r_olast;

endmodule

FILE: tb/sv/tb_xoshiro256ss_rng_with_shuffle.sv
module tb_xoshiro256ss_rng_with_shuffle;
    timeunit 1ns;
    timeprecision 1ps;

    import xss_pkg::*;

    typedef struct packed {
        t_value value;
        logic   last;
    } rng_result_t;

    class rng_tracker;
        t_value      gen[4];
        int          shuffle[MAX_PERM];
        rng_result_t due_values[$];
        int          errors;
        int          checked;
        int          requests[4];

        function new();
            for (int k = 0; k < 4; k++) begin
                gen[k] = '0;
                requests[k] = 0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function int pending();
            return due_values.size();
        endfunction

        function t_value rotl(t_value v, int s);
            return (v << s) | (v >> (64 - s));
        endfunction

        function void splitmix_seed(t_seed s);
            t_value acc;
            t_value z;
            acc = s;
            for (int w = 0; w < 4; w++) begin
                acc = acc + SM_GAMMA;
                z = acc;
                z = (z ^ (z >> 30)) * SM_MUL1;
                z = (z ^ (z >> 27)) * SM_MUL2;
                gen[w] = z ^ (z >> 31);
            end
        endfunction

        function t_value next_word();
            t_value word;
            t_value sh;
            word = rotl(gen[1] * 64'd5, 7) * 64'd9;
            sh = gen[1] << 17;
            gen[2] = gen[2] ^ gen[0];
            gen[3] = gen[3] ^ gen[1];
            gen[1] = gen[1] ^ gen[2];
            gen[0] = gen[0] ^ gen[3];
            gen[2] = gen[2] ^ sh;
            gen[3] = rotl(gen[3], 45);
            return word;
        endfunction

        // exact floor(top53 * b / 2^53)
        function t_value scaled_draw(t_value b);
            logic [127:0] prod;
            t_value       frac;
            frac = next_word() >> 11;
            prod = 128'(frac) * 128'(b);
            return t_value'(prod >> 53);
        endfunction

        function void note_request(t_op op, t_seed s, t_bound b);
            int n;
            int j;
            int t;
            requests[op]++;
            case (op)
                OP_SEED: begin
                    splitmix_seed(s);
                end
                OP_RAW: begin
                    due_values.push_back('{value: next_word(), last: 1'b1});
                end
                OP_BOUNDED: begin
                    due_values.push_back('{value: scaled_draw(t_value'(b)), last: 1'b1});
                end
                default: begin
                    n = (b > MAX_PERM) ? MAX_PERM : int'(b);
                    for (int i = 0; i < n; i++) shuffle[i] = i;
                    for (int i = n - 1; i > 0; i--) begin
                        j = int'(scaled_draw(t_value'(i + 1)));
                        if (j > i) j = i;
                        t = shuffle[i];
                        shuffle[i] = shuffle[j];
                        shuffle[j] = t;
                    end
                    for (int i = 0; i < n; i++) begin
                        due_values.push_back('{value: t_value'(shuffle[i]),
                                               last: (i == n - 1)});
                    end
                end
            endcase
        endfunction

        function void check_result(t_value v, logic lst);
            rng_result_t exp_r;
            checked++;
            if (due_values.size() == 0) begin
                $display("%0t: unexpected result: expected none, got value %h last %b",
                         $time, v, lst);
                errors++;
                return;
            end
            exp_r = due_values.pop_front();
            if (v !== exp_r.value) begin
                $display("%0t: value mismatch: expected %h, got %h", $time, exp_r.value, v);
                errors++;
            end
            if (lst !== exp_r.last) begin
                $display("%0t: last mismatch: expected %b, got %b", $time, exp_r.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   hold_cycles;

    rng_tracker sb;

    xss_in_if  in_if();
    xss_out_if out_if();

    xoshiro256ss_rng_with_shuffle dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial begin
        #32_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: sample at the rising edge, decide ready at the falling edge
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
                sb.check_result(out_if.value, out_if.last);
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_request(t_op op, t_seed s, t_bound b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.seed_value <= s;
        in_if.bound      <= b;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sb.note_request(op, s, b);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    function automatic t_seed rand_seed();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_random();
        int     r;
        t_bound b;
        r = $urandom_range(99);
        if (r < 6) begin
            send_request(OP_SEED, rand_seed(), t_bound'($urandom()));
        end else if (r < 36) begin
            send_request(OP_RAW, rand_seed(), t_bound'($urandom()));
        end else if (r < 70) begin
            case ($urandom_range(3))
                0: b = t_bound'($urandom());
                1: b = t_bound'($urandom_range(16));
                2: b = t_bound'($urandom() >> $urandom_range(31));
                default: b = 31'h7FFF_FFFF - t_bound'($urandom_range(3));
            endcase
            send_request(OP_BOUNDED, rand_seed(), b);
        end else begin
            r = $urandom_range(99);
            if (r < 85)      b = t_bound'($urandom_range(1, 8));
            else if (r < 95) b = t_bound'($urandom_range(9, MAX_PERM));
            else if (r < 97) b = '0;
            else             b = t_bound'($urandom());
            send_request(OP_PERM, rand_seed(), b);
        end
    endtask

    task automatic run_directed();
        // unseeded: every draw is zero
        send_request(OP_RAW, '0, '0);
        send_request(OP_BOUNDED, '1, 31'd5);
        send_request(OP_PERM, '0, 31'd0);
        send_request(OP_PERM, '0, 31'd1);
        send_request(OP_PERM, '0, 31'd4);
        send_request(OP_SEED, 64'd0, 31'h7FFF_FFFF);
        send_request(OP_RAW, '1, 31'h7FFF_FFFF);
        send_request(OP_SEED, '1, '0);
        send_request(OP_RAW, '0, '0);
        send_request(OP_BOUNDED, '0, 31'd0);
        send_request(OP_BOUNDED, '0, 31'd1);
        send_request(OP_BOUNDED, '1, 31'h7FFF_FFFF);
        send_request(OP_BOUNDED, '0, 31'h4000_0000);
        send_request(OP_SEED, 64'h8000_0000_0000_0000, 31'h5555_5555);
        send_request(OP_PERM, '1, 31'd2);
        send_request(OP_PERM, '0, 31'd0);
        send_request(OP_PERM, '0, 31'd1);
        send_request(OP_PERM, '0, t_bound'(MAX_PERM));
        send_request(OP_PERM, '0, t_bound'(MAX_PERM + 1));
        send_request(OP_PERM, '0, 31'h7FFF_FFFF);
        send_request(OP_SEED, 64'h0123_4567_89AB_CDEF, '0);
        send_request(OP_RAW, 64'hFEDC_BA98_7654_3210, 31'h2AAA_AAAA);
        send_request(OP_BOUNDED, '0, 31'd3);
        send_request(OP_PERM, '0, 31'd7);
    endtask

    initial begin
        sb = new();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = OP_SEED;
        in_if.seed_value = '0;
        in_if.bound = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_drained();

        src_idle_pct = 23;
        snk_idle_pct = 80;
        send_request(OP_SEED, rand_seed(), t_bound'($urandom()));
        repeat (130) send_random();
        wait_drained();

        src_idle_pct = 80;
        snk_idle_pct = 23;
        repeat (130) send_random();
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        // hold off the result side while requests keep coming
        hold_cycles = 300;
        repeat (10) send_request(OP_RAW, rand_seed(), t_bound'($urandom()));
        send_request(OP_PERM, rand_seed(), 31'd6);
        send_request(OP_BOUNDED, rand_seed(), t_bound'($urandom()));
        repeat (130) send_random();
        wait_drained();

        repeat (1000) @(posedge clk);
        $display("Requests: %0d seed, %0d raw, %0d bounded, %0d permutation",
                 sb.requests[OP_SEED], sb.requests[OP_RAW],
                 sb.requests[OP_BOUNDED], sb.requests[OP_PERM]);
        $display("Results checked: %0d, errors: %0d", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: xoshiro256ss_rng_with_shuffle.f
rtl/xss_pkg.sv
rtl/xss_in_if.sv
rtl/xss_out_if.sv
rtl/xss_ram.sv
rtl/xoshiro256ss_rng_with_shuffle.sv
tb/sv/tb_xoshiro256ss_rng_with_shuffle.sv
